// ----- hdl/rgb_to_hsv_converter_top_macros.svh -----
// Assertion macros shared by the RTL; ASSERT_OFF strips them out.
// Both macros sample on clk; the first is gated by the active-low reset rst_n.
`ifndef RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHC_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHC_ASSERT(label, prop, msg)
`define RHC_ASSERT_NORST(label, prop, msg)
`endif
`endif

// ----- hdl/rhc_pkg.sv -----
package rhc_pkg;

  // Number of division cells: one quotient bit per cell, 13 bits per lane
  localparam int RHC_CELLS = 13;

  localparam logic [14:0] HUE_BASE_R = 15'd0;
  localparam logic [14:0] HUE_BASE_G = 15'd7680;
  localparam logic [14:0] HUE_BASE_B = 15'd15360;
  localparam logic [15:0] HUE_FULL   = 16'd23040;

  // One restoring-division lane: partial remainder, numerator bits still
  // to shift in (MSB first), divisor and quotient collected so far.
  typedef struct packed {
    logic [7:0]  rem;
    logic [12:0] num;
    logic [7:0]  div;
    logic [12:0] quo;
  } rhc_lane_t;

  typedef struct packed {
    rhc_lane_t   sat;
    rhc_lane_t   hue;
    logic [14:0] base;
    logic        neg;
    logic        undef;
    logic [7:0]  value;
  } rhc_item_t;

  // Shift in one numerator bit, compare, subtract: one quotient bit.
  function automatic rhc_lane_t rhc_div_step(rhc_lane_t l);
    rhc_lane_t  o;
    logic [8:0] t;
    logic [8:0] d;
    o = l;
    t = {l.rem, l.num[12]};
    d = t - {1'b0, l.div};
    if (t >= {1'b0, l.div}) begin
      o.rem = d[7:0];
      o.quo = {l.quo[11:0], 1'b1};
    end else begin
      o.rem = t[7:0];
      o.quo = {l.quo[11:0], 1'b0};
    end
    o.num = {l.num[11:0], 1'b0};
    return o;
  endfunction

endpackage

// ----- hdl/rhc_front.sv -----
module rhc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rhc_pkg::rhc_item_t dn_data
);
  import rhc_pkg::*;

  logic       valid_r, valid_nxt;
  rhc_item_t  data_r, data_nxt;
  logic [7:0] mx, mn, span, hi, lo, d;
  logic [11:0] x15;
  logic [14:0] base;
  logic        neg;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    span = mx - mn;

    // ties go to red, then green
    priority if (red == mx) begin
      base = HUE_BASE_R; hi = green; lo = blue;
    end else if (green == mx) begin
      base = HUE_BASE_G; hi = blue;  lo = red;
    end else begin
      base = HUE_BASE_B; hi = red;   lo = green;
    end
    neg = hi < lo;
    d   = neg ? (lo - hi) : (hi - lo);
    // 3840 = 15 * 256: scale by 15 here, the 256 comes from the fraction bits
    x15 = {d, 4'b0000} - {4'b0000, d};
  end

  always_comb begin
    data_nxt.sat.rem = {1'b0, span[7:1]};
    data_nxt.sat.num = {span[0], 12'h000};
    data_nxt.sat.div = mx;
    data_nxt.sat.quo = '0;
    data_nxt.hue.rem = {1'b0, x15[11:5]};
    data_nxt.hue.num = {x15[4:0], 8'h00};
    data_nxt.hue.div = span;
    data_nxt.hue.quo = '0;
    data_nxt.base    = base;
    data_nxt.neg     = neg;
    data_nxt.undef   = (span == 8'd0);
    data_nxt.value   = mx;
    valid_nxt = up_valid ? 1'b1 : (valid_r && !dn_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- hdl/rhc_cell.sv -----
module rhc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rhc_pkg::rhc_item_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rhc_pkg::rhc_item_t dn_data
);
  import rhc_pkg::*;

  logic      valid_r;
  rhc_item_t data_r, data_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt     = up_data;
    data_nxt.sat = rhc_div_step(up_data.sat);
    data_nxt.hue = rhc_div_step(up_data.hue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- hdl/rhc_back.sv -----
module rhc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rhc_pkg::rhc_item_t up_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        hue,
  output logic               hue_undefined,
  output logic [12:0]        saturation,
  output logic [7:0]         value
);
  import rhc_pkg::*;

  logic        valid_r;
  logic [14:0] hue_r, hue_nxt;
  logic        undef_r;
  logic [12:0] sat_r, sat_nxt;
  logic [7:0]  value_r;
  logic [15:0] sum;
  logic [11:0] mag;

  assign up_ready = !valid_r || out_ready;

  always_comb begin
    mag = up_data.hue.quo[11:0];
    if (up_data.neg) begin
      sum = {1'b0, up_data.base} - {4'b0000, mag};
      // wrap below zero back onto the circle
      if (sum[15]) sum = sum + HUE_FULL;
    end else begin
      sum = {1'b0, up_data.base} + {4'b0000, mag};
    end
    hue_nxt = up_data.undef ? 15'd0 : sum[14:0];
    // black pixel divides by zero: force saturation to zero
    sat_nxt = (up_data.value == 8'd0) ? 13'd0 : up_data.sat.quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r   <= hue_nxt;
      undef_r <= up_data.undef;
      sat_r   <= sat_nxt;
      value_r <= up_data.value;
    end
  end

  assign out_valid     = valid_r;
  assign hue           = hue_r;
  assign hue_undefined = undef_r;
  assign saturation    = sat_r;
  assign value         = value_r;

endmodule

// ----- hdl/rgb_to_hsv_converter_top.sv -----
// RGB to HSV converter. Takes one pixel per clock while in_tready is high and
// returns one result per pixel, in order. A front stage finds max, min and
// hue sector, thirteen cells of a restoring divider each add one quotient bit
// to both the saturation and the hue division, and a back stage applies the
// sector base and the wrap. Every stage has its own valid bit and may advance
// into an empty slot, so bubbles close up while the output is stalled. Hue is
// in 1/64 degree (0..23039) and reads 0 with tuser set for gray pixels;
// saturation uses 4096 for 1.0.
`include "rgb_to_hsv_converter_top_macros.svh"
module rgb_to_hsv_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // hue[14:0], saturation[27:15], value[35:28], zero
  output logic        out_tuser   // hue_undefined
);
  import rhc_pkg::*;

  logic      cv   [RHC_CELLS+1];
  logic      crdy [RHC_CELLS+1];
  rhc_item_t cd   [RHC_CELLS+1];

  logic [14:0] hue;
  logic        hue_undefined;
  logic [12:0] saturation;
  logic [7:0]  value;

  rhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .red      (in_tdata[7:0]),
    .green    (in_tdata[15:8]),
    .blue     (in_tdata[23:16]),
    .dn_valid (cv[0]),
    .dn_ready (crdy[0]),
    .dn_data  (cd[0])
  );

  for (genvar k = 0; k < RHC_CELLS; k++) begin : g_cell
    rhc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_ready (crdy[k]),
      .up_data  (cd[k]),
      .dn_valid (cv[k+1]),
      .dn_ready (crdy[k+1]),
      .dn_data  (cd[k+1])
    );
  end

  rhc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (cv[RHC_CELLS]),
    .up_ready      (crdy[RHC_CELLS]),
    .up_data       (cd[RHC_CELLS]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .hue           (hue),
    .hue_undefined (hue_undefined),
    .saturation    (saturation),
    .value         (value)
  );

  assign out_tdata = {4'b0000, value, saturation, hue};
  assign out_tuser = hue_undefined;

  `RHC_ASSERT(a_gray_hue_zero, out_tvalid && out_tuser |-> out_tdata[14:0] == 15'd0, "gray pixel with nonzero hue")
  `RHC_ASSERT(a_hue_range, out_tvalid |-> out_tdata[14:0] < 15'd23040, "hue beyond full circle")
  `RHC_ASSERT(a_colour_sat, out_tvalid && !out_tuser |-> out_tdata[27:15] != 13'd0, "coloured pixel with zero saturation")
  `RHC_ASSERT(a_sat_range, out_tvalid |-> out_tdata[27:15] <= 13'd4096, "saturation above one")
  `RHC_ASSERT(a_black_sat, out_tvalid && out_tdata[35:28] == 8'd0 |-> out_tdata[27:15] == 13'd0 && out_tuser, "black pixel not gray")

endmodule
